@@ hdl/peak_power_energy_accumulator_unit_assert.svh @@
// Assertion macros for the peak power energy accumulator checker.
// No dependencies.
`ifndef PEAK_POWER_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH
`define PEAK_POWER_ENERGY_ACCUMULATOR_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define PPEA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppea assertion failed");

// Condition that must never be seen at a clock edge.
`define PPEA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `PPEA_ASSERT(lbl, clk, rst_n, !(cond))

`endif

@@ hdl/ppea_pkg.sv @@
// Package for the peak power energy accumulator: field widths, register map,
// configuration struct and reset constants. No dependencies.
package ppea_pkg;

  localparam int KIND_W       = 1;
  localparam int SAMPLE_W     = 10;
  localparam int TIME_W       = 32;
  localparam int HOUR_W       = 5;
  localparam int MINUTE_W     = 6;
  localparam int POWER_W      = 12;
  localparam int ENERGY_OUT_W = 48;
  localparam int GAIN_W       = 16;
  localparam int THRESH_W     = 12;
  localparam int FRAC_BITS    = 12;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 1;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_GAIN   = 1'b0;
  localparam reg_idx_t REG_THRESH = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd12893;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd300;
  localparam logic [HOUR_W-1:0]   HOUR_NONE    = 5'd31;
  localparam logic [POWER_W-1:0]  POWER_MAX    = 12'd4095;
  localparam logic [FRAC_BITS-1:0] ROUND_HALF  = 12'd2048;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [THRESH_W-1:0] threshold;
  } ppea_cfg_t;

endpackage

@@ hdl/ppea_if.sv @@
// Item channel interfaces for the peak power energy accumulator.
// Depends on ppea_pkg.
interface ppea_in_if;
  import ppea_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   time_ms;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;

  modport source (output valid, kind, sample, time_ms, hour, minute, input ready);
  modport sink   (input valid, kind, sample, time_ms, hour, minute, output ready);
endinterface

interface ppea_out_if;
  import ppea_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [POWER_W-1:0]      power_w;
  logic                    report_valid;
  logic [ENERGY_OUT_W-1:0] energy_wms;

  modport source (output valid, power_w, report_valid, energy_wms, input ready);
  modport sink   (input valid, power_w, report_valid, energy_wms, output ready);
endinterface

@@ hdl/ppea_apb_regs.sv @@
// APB configuration registers: power gain and power threshold.
// Depends on ppea_pkg.
module ppea_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppea_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppea_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppea_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ppea_pkg::ppea_cfg_t           cfg_o
);
  import ppea_pkg::*;

  ppea_cfg_t cfg_q;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain      <= GAIN_RESET;
      cfg_q.threshold <= THRESH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN:   cfg_q.gain      <= pwdata[GAIN_W-1:0];
        REG_THRESH: cfg_q.threshold <= pwdata[THRESH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN:   prdata = PDATA_W'(cfg_q.gain);
      REG_THRESH: prdata = PDATA_W'(cfg_q.threshold);
    endcase
  end

endmodule

@@ hdl/ppea_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// No dependencies.
module ppea_serial_mul #(
  parameter int A_W = 12,
  parameter int B_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic [A_W+B_W-1:0] prod_o,
  output logic             done_o
);
  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(A_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [P_W-1:0]   acc_q;
  logic [A_W-1:0]   a_q;
  logic [B_W-1:0]   b_q;

  assign prod_o = acc_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(A_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << 1) + (a_q[A_W-1] ? P_W'(b_q) : '0);
      a_q   <= a_q << 1;
    end
  end

endmodule

@@ hdl/peak_power_energy_accumulator_unit.sv @@
// Peak power energy accumulator top level: peak tracking, power and energy
// sequencing, hourly report. Depends on ppea_pkg, ppea_if, ppea_apb_regs, ppea_serial_mul.
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | kind, sample, time_ms, hour, minute
//  out_o   | out | valid/ready   | power_w, report_valid, energy_wms
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// A sample item only updates the peak and gives no result.
// A close item runs two serial multiplies in turn: the gain multiply takes one
// peak bit per cycle, then the energy multiply one bit of the 12-bit power per cycle.
// A finished result waits until the output register is free; input accepts again
// once it is loaded. Reset clears peak, time and energy; last hour resets to 31.
module peak_power_energy_accumulator_unit #(
  parameter int ADC_BITS    = 10,
  parameter int ENERGY_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ppea_in_if.sink                       in_i,
  ppea_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppea_pkg::PADDR_W-1:0]  paddr,
  input  logic [ppea_pkg::PDATA_W-1:0]  pwdata,
  output logic [ppea_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ppea_pkg::*;

  localparam int PROD1_W = ADC_BITS + GAIN_W;
  localparam int PRAW_W  = PROD1_W + 1 - FRAC_BITS;
  localparam int PROD2_W = POWER_W + TIME_W;
  localparam int SUM_W   = ((ENERGY_BITS > PROD2_W) ? ENERGY_BITS : PROD2_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_GAIN, S_ENERGY, S_OUT} state_e;

  state_e                   state_q;
  logic [ADC_BITS-1:0]      peak_q;
  logic [TIME_W-1:0]        last_time_q;
  logic [TIME_W-1:0]        elapsed_q;
  logic [ENERGY_BITS-1:0]   energy_q;
  logic [HOUR_W-1:0]        last_hour_q;
  logic [HOUR_W-1:0]        hour_q;
  logic [MINUTE_W-1:0]      minute_q;
  logic [POWER_W-1:0]       p_q;
  logic                     res_valid_q;
  logic [ENERGY_OUT_W-1:0]  res_energy_q;
  logic                     out_valid_q;
  logic [POWER_W-1:0]       out_power_q;
  logic                     out_report_q;
  logic [ENERGY_OUT_W-1:0]  out_energy_q;

  ppea_cfg_t                cfg;
  logic                     in_acc;
  logic [ADC_BITS-1:0]      sample_m;
  logic [PROD1_W-1:0]       prod1;
  logic                     done1;
  logic [PROD2_W-1:0]       prod2;
  logic                     done2;
  logic [PROD1_W:0]         rsum;
  logic [PRAW_W-1:0]        p_raw;
  logic [POWER_W-1:0]       p_d;
  logic [SUM_W-1:0]         sum;
  logic [ENERGY_BITS-1:0]   total_d;
  logic                     report_d;
  logic                     out_free;

  ppea_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppea_serial_mul #(.A_W(ADC_BITS), .B_W(GAIN_W)) u_mul_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (in_i.kind == KIND_CLOSE)),
    .a_i     (peak_q),
    .b_i     (cfg.gain),
    .prod_o  (prod1),
    .done_o  (done1)
  );

  ppea_serial_mul #(.A_W(POWER_W), .B_W(TIME_W)) u_mul_energy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (done1),
    .a_i     (p_d),
    .b_i     (elapsed_q),
    .prod_o  (prod2),
    .done_o  (done2)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign sample_m   = ADC_BITS'(in_i.sample);

  // round half up, threshold on the unsaturated value, then saturate
  assign rsum  = {1'b0, prod1} + (PROD1_W+1)'(ROUND_HALF);
  assign p_raw = rsum[PROD1_W:FRAC_BITS];
  always_comb begin
    if (p_raw < PRAW_W'(cfg.threshold)) begin
      p_d = '0;
    end else if (p_raw > PRAW_W'(POWER_MAX)) begin
      p_d = POWER_MAX;
    end else begin
      p_d = p_raw[POWER_W-1:0];
    end
  end

  assign sum      = SUM_W'(energy_q) + SUM_W'(prod2);
  assign total_d  = (sum[SUM_W-1:ENERGY_BITS] != '0) ? '1 : sum[ENERGY_BITS-1:0];
  assign report_d = (minute_q == '0) && (hour_q != last_hour_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.power_w      = out_power_q;
  assign out_o.report_valid = out_report_q;
  assign out_o.energy_wms   = out_energy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      peak_q       <= '0;
      last_time_q  <= '0;
      elapsed_q    <= '0;
      energy_q     <= '0;
      last_hour_q  <= HOUR_NONE;
      hour_q       <= '0;
      minute_q     <= '0;
      p_q          <= '0;
      res_valid_q  <= 1'b0;
      res_energy_q <= '0;
      out_valid_q  <= 1'b0;
      out_power_q  <= '0;
      out_report_q <= 1'b0;
      out_energy_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.kind == KIND_SAMPLE) begin
              if (sample_m > peak_q) begin
                peak_q <= sample_m;
              end
            end else begin
              peak_q      <= '0;
              elapsed_q   <= in_i.time_ms - last_time_q;
              last_time_q <= in_i.time_ms;
              hour_q      <= in_i.hour;
              minute_q    <= in_i.minute;
              state_q     <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          if (done1) begin
            p_q     <= p_d;
            state_q <= S_ENERGY;
          end
        end
        S_ENERGY: begin
          if (done2) begin
            res_valid_q <= report_d;
            if (report_d) begin
              res_energy_q <= ENERGY_OUT_W'(total_d);
              energy_q     <= '0;
              last_hour_q  <= hour_q;
            end else begin
              res_energy_q <= '0;
              energy_q     <= total_d;
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_power_q  <= p_q;
            out_report_q <= res_valid_q;
            out_energy_q <= res_energy_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/ppea_checker.sv @@
// Port-level checker for the peak power energy accumulator, with its bind.
// Depends on peak_power_energy_accumulator_unit_assert.svh and ppea_pkg.
`include "peak_power_energy_accumulator_unit_assert.svh"

module ppea_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic [ppea_pkg::KIND_W-1:0]            in_kind_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic [ppea_pkg::POWER_W-1:0]           out_power_i,
  input logic                                   out_report_i,
  input logic [ppea_pkg::ENERGY_OUT_W-1:0]      out_energy_i
);
  import ppea_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  `PPEA_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_power_i) && $stable(out_report_i) && $stable(out_energy_i)))
  `PPEA_ASSERT_NEVER(a_energy_no_report, clk_i, rst_ni, out_valid_i && !out_report_i && (out_energy_i != '0))
  `PPEA_ASSERT(a_close_busy, clk_i, rst_ni, (in_acc && (in_kind_i == KIND_CLOSE)) |=> !in_ready_i)
  `PPEA_ASSERT(a_sample_fast, clk_i, rst_ni, (in_acc && (in_kind_i == KIND_SAMPLE)) |=> in_ready_i)

endmodule

bind peak_power_energy_accumulator_unit ppea_checker u_ppea_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_kind_i    (in_i.kind),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_power_i  (out_o.power_w),
  .out_report_i (out_o.report_valid),
  .out_energy_i (out_o.energy_wms)
);

@@ dv/testbench.sv @@
// Testbench for peak_power_energy_accumulator_unit: drives samples and window
// closes over the item channels and the APB registers, predicts each reading.
// Depends on ppea_pkg, ppea_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
  import ppea_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_ms;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } meter_item_t;

  typedef struct packed {
    logic [POWER_W-1:0]      power_w;
    logic                    report_valid;
    logic [ENERGY_OUT_W-1:0] energy_wms;
  } meter_reading_t;

  class energy_scoreboard;
    logic [GAIN_W-1:0]       gain;
    logic [THRESH_W-1:0]     thresh;
    logic [SAMPLE_W-1:0]     peak;
    logic [TIME_W-1:0]       last_ms;
    logic [ENERGY_OUT_W-1:0] total;
    logic [HOUR_W-1:0]       last_hr;
    meter_reading_t          due_readings[$];
    int                      errors;
    int                      closes;
    int                      reports;
    int                      saturations;

    function new();
      gain    = GAIN_RESET;
      thresh  = THRESH_RESET;
      peak    = '0;
      last_ms = '0;
      total   = '0;
      last_hr = HOUR_NONE;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_GAIN:   gain = val[GAIN_W-1:0];
        REG_THRESH: thresh = val[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    // Accepted input item: track the peak or close the window.
    function void take_item(meter_item_t it);
      logic [27:0]             scaled;
      logic [15:0]             watts_raw;
      logic [POWER_W-1:0]      watts;
      logic [TIME_W-1:0]       span;
      logic [ENERGY_OUT_W:0]   sum;
      meter_reading_t          r;
      if (it.kind == KIND_SAMPLE) begin
        if (it.sample > peak) peak = it.sample;
        return;
      end
      scaled    = 28'(peak) * 28'(gain) + 28'(ROUND_HALF);
      watts_raw = 16'(scaled >> FRAC_BITS);
      if (watts_raw < 16'(thresh)) watts = '0;
      else if (watts_raw > 16'(POWER_MAX)) watts = POWER_MAX;
      else watts = watts_raw[POWER_W-1:0];
      span    = it.time_ms - last_ms;
      last_ms = it.time_ms;
      sum     = {1'b0, total} + (49'(watts) * 49'(span));
      if (sum[ENERGY_OUT_W]) begin
        total = '1;
        saturations++;
      end else begin
        total = sum[ENERGY_OUT_W-1:0];
      end
      peak = '0;
      r.power_w      = watts;
      r.report_valid = 1'b0;
      r.energy_wms   = '0;
      if (it.minute == '0 && it.hour != last_hr) begin
        r.report_valid = 1'b1;
        r.energy_wms   = total;
        total          = '0;
        last_hr        = it.hour;
        reports++;
      end
      closes++;
      due_readings.push_back(r);
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      if (due_readings.size() == 0) begin
        $error("unexpected reading: power_w %0d report_valid %0d energy_wms %0d",
               got.power_w, got.report_valid, got.energy_wms);
        errors++;
        return;
      end
      want = due_readings.pop_front();
      if (got.power_w !== want.power_w) begin
        $error("power_w: expected %0d, got %0d", want.power_w, got.power_w);
        errors++;
      end
      if (got.report_valid !== want.report_valid) begin
        $error("report_valid: expected %0d, got %0d", want.report_valid, got.report_valid);
        errors++;
      end
      if (got.energy_wms !== want.energy_wms) begin
        $error("energy_wms: expected %0d, got %0d", want.energy_wms, got.energy_wms);
        errors++;
      end
    endfunction

    function int pending();
      return due_readings.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ppea_in_if  in_if();
  ppea_out_if out_if();

  peak_power_energy_accumulator_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  energy_scoreboard board = new();

  logic              calm = 1'b0;
  logic              hold_req = 1'b0;
  int                hold_left = 0;
  int                cycle_count = 0;
  int                items_sent = 0;
  int                settings = 1;
  logic [TIME_W-1:0] clock_ms = '0;
  int                hr = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random backpressure, long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready)
      board.check_reading({out_if.power_w, out_if.report_valid, out_if.energy_wms});
  end

  function automatic meter_item_t pack_item(logic [KIND_W-1:0] k, int s, logic [TIME_W-1:0] t,
                                            int h, int m);
    meter_item_t it;
    it.kind    = k;
    it.sample  = SAMPLE_W'(s);
    it.time_ms = t;
    it.hour    = HOUR_W'(h);
    it.minute  = MINUTE_W'(m);
    return it;
  endfunction

  task automatic push(meter_item_t it);
    if (!calm && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= it.kind;
    in_if.sample  <= it.sample;
    in_if.time_ms <= it.time_ms;
    in_if.hour    <= it.hour;
    in_if.minute  <= it.minute;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic wait_readings();
    in_if.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_readings();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] got;
    logic [PDATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    want = (idx == REG_GAIN) ? PDATA_W'(board.gain) : PDATA_W'(board.thresh);
    got  = (idx == REG_GAIN) ? PDATA_W'(got[GAIN_W-1:0]) : PDATA_W'(got[THRESH_W-1:0]);
    if (got !== want) begin
      $error("prdata: expected %0d, got %0d", want, got);
      board.errors++;
    end
  endtask

  task automatic configure(int gain_val, int thresh_val);
    settle();
    reg_write(REG_GAIN, {16'($urandom), 16'(gain_val)});
    reg_write(REG_THRESH, {20'($urandom), 12'(thresh_val)});
    @(posedge clk_i);
    settings++;
  endtask

  task automatic close_window(int m);
    int r;
    r = $urandom_range(99);
    if (r < 10) clock_ms += $urandom;
    else if (r < 40) clock_ms += $urandom_range(0, 200000);
    else clock_ms += $urandom_range(0, 3000);
    push(pack_item(KIND_CLOSE, $urandom_range(0, 1023), clock_ms, hr, m));
  endtask

  // Measurement windows with random content, with some noise mixed in.
  task automatic stir(int budget);
    int left;
    int r;
    left = budget;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push(pack_item(KIND_W'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom,
                       $urandom_range(0, 31), $urandom_range(0, 63)));
        left--;
      end else begin
        repeat ($urandom_range(0, 6)) begin
          push(pack_item(KIND_SAMPLE,
                         ($urandom_range(99) < 30) ? $urandom_range(0, 150)
                                                   : $urandom_range(0, 1023),
                         $urandom, $urandom_range(0, 31), $urandom_range(0, 63)));
          left--;
        end
        r = $urandom_range(99);
        if (r < 35) begin
          hr = (hr + 1) % 24;
          close_window(0);
        end else if (r < 45) begin
          close_window(0);
        end else if (r < 50) begin
          hr = $urandom_range(0, 31);
          close_window(0);
        end else begin
          close_window($urandom_range(1, 59));
        end
        left--;
      end
    end
  endtask

  // Full-scale windows of nearly 2^32 ms each until the total pins at max.
  task automatic fill_total();
    repeat (18) begin
      push(pack_item(KIND_SAMPLE, 1023, $urandom, $urandom_range(0, 31), 0));
      clock_ms += 32'hFFFF_FFFF;
      push(pack_item(KIND_CLOSE, 0, clock_ms, hr, 7));
    end
    hr = (int'(board.last_hr) + 1) % 24;
    push(pack_item(KIND_CLOSE, 0, clock_ms, hr, 0));
  endtask

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_if.valid    <= 1'b0;
    in_if.kind     <= KIND_SAMPLE;
    in_if.sample   <= '0;
    in_if.time_ms  <= '0;
    in_if.hour     <= '0;
    in_if.minute   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, reset register values.
    push(pack_item(KIND_CLOSE, 0, 32'd0, 31, 0));
    push(pack_item(KIND_SAMPLE, 0, 32'd0, 0, 0));
    push(pack_item(KIND_SAMPLE, 1023, 32'd0, 0, 0));
    push(pack_item(KIND_SAMPLE, 5, 32'd0, 0, 0));
    push(pack_item(KIND_CLOSE, 0, 32'd1000, 0, 0));
    push(pack_item(KIND_SAMPLE, 95, 32'd0, 0, 0));
    push(pack_item(KIND_CLOSE, 0, 32'd2000, 0, 30));
    push(pack_item(KIND_SAMPLE, 96, 32'd0, 0, 0));
    push(pack_item(KIND_CLOSE, 0, 32'd3000, 0, 0));
    push(pack_item(KIND_SAMPLE, 10'h2AA, 32'd0, 0, 0));
    push(pack_item(KIND_SAMPLE, 10'h155, 32'd0, 0, 0));
    push(pack_item(KIND_CLOSE, 0, 32'hFFFF_FFF0, 1, 0));
    push(pack_item(KIND_SAMPLE, 300, 32'd0, 0, 0));
    push(pack_item(KIND_CLOSE, 0, 32'h10, 24, 0));
    push(pack_item(KIND_CLOSE, 0, 32'h20, 31, 0));
    push(pack_item(KIND_CLOSE, 0, 32'h30, 31, 0));
    push(pack_item(KIND_CLOSE, 0, 32'h40, 5, 63));
    push(pack_item(KIND_SAMPLE, 400, 32'hDEAD_BEEF, 31, 63));
    push(pack_item(KIND_CLOSE, 1023, 32'h50, 5, 0));
    clock_ms = 32'h50;
    hr = 5;

    configure(16'hFFFF, 12'hFFF);
    fill_total();
    stir(120);

    configure(0, 0);
    stir(60);

    configure($urandom_range(0, 65535), 0);
    hold_req = 1'b1;
    stir(100);
    wait_readings();
    stir(100);

    configure($urandom_range(0, 65535), $urandom_range(0, 4095));
    stir(60);
    calm = 1'b1;
    stir(80);
    calm = 1'b0;
    stir(60);

    configure(GAIN_RESET, THRESH_RESET);
    stir(80);

    settle();
    $display("Covered %0d items: %0d window closes, %0d hourly reports, %0d saturating adds,",
             items_sent, board.closes, board.reports, board.saturations);
    $display("across %0d gain/threshold settings with random stalls on both channels.",
             settings);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ppea_pkg.sv
hdl/ppea_if.sv
hdl/ppea_apb_regs.sv
hdl/ppea_serial_mul.sv
hdl/peak_power_energy_accumulator_unit.sv
hdl/ppea_checker.sv
dv/testbench.sv
